>>> rtl/core/vdl_pkg.sv
`default_nettype none
package vdl_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegDensityMin = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDensityMax = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLevelCount = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDensityFill = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLevelFill = 3'd4;

  localparam logic signed [27:0] KBase = -28'sd122104578;
  localparam logic signed [20:0] KNdvi = 21'sd982712;
  localparam logic signed [23:0] KDist = 24'sd6637013;
  localparam logic signed [22:0] KBright = 23'sd2949841;
  localparam logic signed [16:0] KBlue = 17'sd21365;
  localparam logic signed [16:0] KGreen = 17'sd33358;
  localparam logic signed [16:0] KRed = 17'sd36700;
  localparam logic signed [16:0] KNir = 17'sd37159;

  localparam logic signed [15:0] NdviOne = 16'sd16384;

  // quotient bits per divider stage
  localparam int unsigned NdviStep = 3;
  localparam int unsigned LvlStep = 3;

  typedef struct packed {
    logic               mask;
    logic               zero;
    logic               neg;
    logic [15:0]        nir;
    logic [15:0]        wdist;
    logic signed [32:0] p_blue;
    logic signed [32:0] p_green;
    logic signed [32:0] p_red;
    logic signed [32:0] p_nir;
  } ndvi_side_t;

  typedef struct packed {
    logic        mask;
    logic        neg;
    logic        cnt_zero;
    logic        den_zero;
    logic signed [15:0] clamped;
  } lvl_side_t;

endpackage
`default_nettype wire

>>> rtl/core/vdl_if.sv
`default_nettype none
interface vdl_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] blue_band;
  logic [15:0] green_band;
  logic [15:0] red_band;
  logic [15:0] nir_band;
  logic [15:0] water_distance;
  modport source (output valid, blue_band, green_band, red_band, nir_band, water_distance,
                  input ready);
  modport sink (input valid, blue_band, green_band, red_band, nir_band, water_distance,
                output ready);
endinterface

interface vdl_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] density;
  logic [15:0] level;
  logic        in_mask;
  modport source (output valid, density, level, in_mask, input ready);
  modport sink (input valid, density, level, in_mask, output ready);
endinterface
`default_nettype wire

>>> rtl/core/vdl_div.sv
`default_nettype none
module vdl_div #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 1,
  parameter int unsigned STEP = 3
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [DW-1:0]      rem_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned NS = NW / STEP;

  logic          v_q [NS];
  logic [NW-1:0] n_q [NS];
  logic [DW-1:0] r_q [NS];
  logic [DW-1:0] d_q [NS];
  logic [SW-1:0] s_q [NS];

  for (genvar g = 0; g < NS; g++) begin : g_st
    logic          v_in;
    logic [NW-1:0] n_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [NW-1:0] n_nx;
    logic [DW-1:0] r_nx;

    if (g == 0) begin : g_first
      assign v_in = valid_i;
      assign n_in = num_i;
      assign r_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[g-1];
      assign n_in = n_q[g-1];
      assign r_in = r_q[g-1];
      assign d_in = d_q[g-1];
      assign s_in = s_q[g-1];
    end

    // restoring division, STEP quotient bits per stage
    always_comb begin
      logic [DW:0] t;
      n_nx = n_in;
      r_nx = r_in;
      t = '0;
      for (int k = 0; k < STEP; k++) begin
        t = {r_nx, n_nx[NW-1]};
        if (t >= {1'b0, d_in}) begin
          t = t - {1'b0, d_in};
          n_nx = {n_nx[NW-2:0], 1'b1};
        end else begin
          n_nx = {n_nx[NW-2:0], 1'b0};
        end
        r_nx = t[DW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[g] <= n_nx;
        r_q[g] <= r_nx;
        d_q[g] <= d_in;
        s_q[g] <= s_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign quo_o   = n_q[NS-1];
  assign rem_o   = r_q[NS-1];
  assign side_o  = s_q[NS-1];

endmodule
`default_nettype wire

>>> rtl/core/vegetation_density_level.sv
// pipeline from input transfer to result: ndvi divider 10 stages,
// level divider 8 stages, 6 arithmetic and output stages
// throughput: one pixel per cycle; the whole pipeline holds while a result waits
// reset: asynchronous active low, clears all valid bits and loads the register
// defaults (min -512, max 2048, count 10, density fill 0, level fill -1)
`default_nettype none
module vegetation_density_level
  import vdl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  vdl_pix_if.sink                 pix_i,
  vdl_res_if.source               res_o
);

  logic [15:0] density_min_q, density_max_q, density_fill_q, level_fill_q;
  logic [7:0]  level_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      density_min_q  <= 16'hFE00;
      density_max_q  <= 16'd2048;
      level_count_q  <= 8'd10;
      density_fill_q <= 16'd0;
      level_fill_q   <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDensityMin:  density_min_q  <= cfg_data_i;
        RegDensityMax:  density_max_q  <= cfg_data_i;
        RegLevelCount:  level_count_q  <= cfg_data_i[7:0];
        RegDensityFill: density_fill_q <= cfg_data_i;
        RegLevelFill:   level_fill_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || res_o.ready;
  assign pix_i.ready = en;

  logic signed [15:0] lo, hi;
  assign lo = $signed(density_min_q);
  assign hi = $signed(density_max_q);

  // stage 1: mask, ndvi operands, brightness products
  logic signed [16:0] red_s, nir_s, sum_s, diff_s;
  logic [15:0]        diff_mag;
  ndvi_side_t         s1_d, s1_q;
  logic               s1_v_q;
  logic [29:0]        s1_num_q;
  logic [15:0]        s1_den_q;

  always_comb begin
    red_s  = {pix_i.red_band[15], pix_i.red_band};
    nir_s  = {pix_i.nir_band[15], pix_i.nir_band};
    sum_s  = nir_s + red_s;
    diff_s = nir_s - red_s;
    diff_mag = diff_s[16] ? 16'(-diff_s) : diff_s[15:0];
    s1_d.mask    = !pix_i.red_band[15] && !pix_i.nir_band[15];
    s1_d.zero    = (sum_s == 17'sd0);
    s1_d.neg     = diff_s[16];
    s1_d.nir     = pix_i.nir_band;
    s1_d.wdist   = pix_i.water_distance;
    s1_d.p_blue  = $signed(pix_i.blue_band) * KBlue;
    s1_d.p_green = $signed(pix_i.green_band) * KGreen;
    s1_d.p_red   = $signed(pix_i.red_band) * KRed;
    s1_d.p_nir   = $signed(pix_i.nir_band) * KNir;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      s1_num_q <= {diff_mag, 14'b0};
      s1_den_q <= sum_s[15:0];
    end
  end

  logic        nd_v;
  logic [29:0] nd_quo;
  logic [15:0] nd_rem;
  ndvi_side_t  nd_side;

  vdl_div #(
    .NW(30), .DW(16), .SW($bits(ndvi_side_t)), .STEP(NdviStep)
  ) u_ndvi_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_v_q),
    .num_i   (s1_num_q),
    .den_i   (s1_den_q),
    .side_i  (s1_q),
    .valid_o (nd_v),
    .quo_o   (nd_quo),
    .rem_o   (nd_rem),
    .side_o  (nd_side)
  );

  // stage 2: signed ndvi, brightness sum, first products
  logic signed [15:0] ndvi;
  logic               s2_v_q, s2_mask_q;
  logic signed [15:0] s2_ndvi_q;
  logic signed [32:0] s2_nn_q;
  logic signed [40:0] s2_pd_q;
  logic signed [34:0] s2_br_q;

  always_comb begin
    if (nd_side.zero) begin
      ndvi = 16'sd0;
    end else if (nd_side.neg) begin
      ndvi = -$signed(nd_quo[15:0]);
    end else begin
      ndvi = $signed(nd_quo[15:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= nd_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_mask_q <= nd_side.mask;
      s2_ndvi_q <= ndvi;
      s2_nn_q   <= ndvi * $signed({1'b0, nd_side.nir});
      s2_pd_q   <= $signed({1'b0, nd_side.wdist}) * KDist;
      s2_br_q   <= 35'(nd_side.p_blue) + 35'(nd_side.p_green)
                 + 35'(nd_side.p_red) + 35'(nd_side.p_nir);
    end
  end

  // stage 3: coefficient products
  logic               s3_v_q, s3_mask_q;
  logic signed [53:0] s3_ta_q;
  logic signed [40:0] s3_tb_q;
  logic signed [57:0] s3_tc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_mask_q <= s2_mask_q;
      s3_ta_q   <= s2_nn_q * KNdvi;
      s3_tb_q   <= s2_pd_q;
      s3_tc_q   <= s2_br_q * KBright;
    end
  end

  // stage 4: q.24 sum
  logic signed [53:0] sh_a;
  logic signed [40:0] sh_b;
  logic signed [57:0] sh_c;
  logic signed [39:0] d24;
  logic               s4_v_q, s4_mask_q;
  logic signed [39:0] s4_d24_q;

  always_comb begin
    sh_a = s3_ta_q >>> 18;
    sh_b = s3_tb_q >>> 12;
    sh_c = s3_tc_q >>> 20;
    d24 = 40'(KBase) - 40'(sh_a) - 40'(sh_b) - 40'(sh_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_mask_q <= s3_mask_q;
      s4_d24_q  <= d24;
    end
  end

  // stage 5: round, clamp, level operands
  logic signed [39:0] d_rnd;
  logic signed [23:0] d8;
  logic signed [15:0] clamped;
  logic signed [24:0] lnum;
  logic signed [16:0] lden;
  logic [23:0]        lnum_mag;
  logic [15:0]        lden_mag;
  lvl_side_t          s5_d, s5_q;
  logic               s5_v_q;
  logic [23:0]        s5_num_q;
  logic [15:0]        s5_den_q;

  always_comb begin
    d_rnd = (s4_d24_q + 40'sd32768) >>> 16;
    d8    = d_rnd[23:0];
    if (d8 < 24'(lo)) begin
      clamped = lo;
    end else if (d8 > 24'(hi)) begin
      clamped = hi;
    end else begin
      clamped = d8[15:0];
    end
    lnum     = clamped * $signed({1'b0, level_count_q});
    lden     = 17'(hi) - 17'(lo);
    lnum_mag = lnum[24] ? 24'(-lnum) : lnum[23:0];
    lden_mag = lden[16] ? 16'(-lden) : lden[15:0];
    s5_d.mask     = s4_mask_q;
    s5_d.neg      = (lnum[24] != lden[16]);
    s5_d.cnt_zero = (level_count_q == 8'd0);
    s5_d.den_zero = (lden == 17'sd0);
    s5_d.clamped  = clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q     <= s5_d;
      s5_num_q <= lnum_mag;
      s5_den_q <= lden_mag;
    end
  end

  logic        lv_v;
  logic [23:0] lv_quo;
  logic [15:0] lv_rem;
  lvl_side_t   lv_side;

  vdl_div #(
    .NW(24), .DW(16), .SW($bits(lvl_side_t)), .STEP(LvlStep)
  ) u_lvl_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_v_q),
    .num_i   (s5_num_q),
    .den_i   (s5_den_q),
    .side_i  (s5_q),
    .valid_o (lv_v),
    .quo_o   (lv_quo),
    .rem_o   (lv_rem),
    .side_o  (lv_side)
  );

  // output stage: floor sign fix, saturation, fill
  logic signed [25:0] q_s;
  logic signed [15:0] lvl;
  logic [15:0]        density_q, level_q;
  logic               in_mask_q;

  always_comb begin
    if (lv_side.neg) begin
      q_s = -($signed({2'b0, lv_quo}) + 26'(lv_rem != 16'd0));
    end else begin
      q_s = $signed({2'b0, lv_quo});
    end
    if (lv_side.cnt_zero) begin
      lvl = 16'sd0;
    end else if (lv_side.den_zero) begin
      lvl = (lv_side.clamped > 16'sd0) ? 16'sd32767
          : ((lv_side.clamped < 16'sd0) ? -16'sd32768 : 16'sd0);
    end else if (q_s > 26'sd32767) begin
      lvl = 16'sd32767;
    end else if (q_s < -26'sd32768) begin
      lvl = -16'sd32768;
    end else begin
      lvl = q_s[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= lv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_mask_q <= lv_side.mask;
      density_q <= lv_side.mask ? lv_side.clamped : density_fill_q;
      level_q   <= lv_side.mask ? lvl : level_fill_q;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.density = density_q;
  assign res_o.level   = level_q;
  assign res_o.in_mask = in_mask_q;

  a_ndvi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_mask_q) |-> (s2_ndvi_q <= NdviOne && s2_ndvi_q >= -NdviOne))
    else $error("ndvi out of range");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.in_mask) |->
      (res_o.density == density_fill_q && res_o.level == level_fill_q))
    else $error("masked pixel without fill values");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.in_mask && lo <= hi) |->
      ($signed(res_o.density) >= lo && $signed(res_o.density) <= hi))
    else $error("density outside clamp range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !en) |=> s1_v_q)
    else $error("pipeline dropped a pixel while stalled");

endmodule
`default_nettype wire

>>> verif/vdl_checker.sv
`timescale 1ns / 1ps
module vdl_checker
  import vdl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  vdl_pix_if                 pix,
  vdl_res_if                 res,
  output int                 fail_cnt_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [15:0] density;
    logic [15:0] level;
    logic        in_mask;
  } px_res_t;

  localparam longint CBase = -64'sd122104578;
  localparam longint CNdvi = 64'sd982712;
  localparam longint CDist = 64'sd6637013;
  localparam longint CBright = 64'sd2949841;
  localparam longint CBlue = 64'sd21365;
  localparam longint CGreen = 64'sd33358;
  localparam longint CRed = 64'sd36700;
  localparam longint CNir = 64'sd37159;

  logic signed [15:0] dens_min, dens_max, dens_fill, lvl_fill;
  logic [7:0]         lvl_count;
  px_res_t            expected_px[$];

  function automatic px_res_t classify_pixel(logic signed [15:0] blue_b, green_b, red_b,
                                             nir_b, logic [15:0] dist_b);
    longint  bl, gr, rd, nr, ds, lo, hi, band_sum, ndvi, bright, d24, d8, den, num, q;
    px_res_t r;
    bl = blue_b;
    gr = green_b;
    rd = red_b;
    nr = nir_b;
    ds = {48'd0, dist_b};
    lo = dens_min;
    hi = dens_max;
    if (rd < 0 || nr < 0) begin
      r.density = dens_fill;
      r.level   = lvl_fill;
      r.in_mask = 1'b0;
      return r;
    end
    band_sum = nr + rd;
    ndvi = (band_sum == 0) ? 0 : ((nr - rd) * 16384) / band_sum;
    if (ndvi < -32768) ndvi = -32768;
    bright = bl * CBlue + gr * CGreen + rd * CRed + nr * CNir;
    d24 = CBase - ((ndvi * nr * CNdvi) >>> 18) - ((ds * CDist) >>> 12)
          - ((bright * CBright) >>> 20);
    d8 = (d24 + 32768) >>> 16;
    if (d8 < lo) d8 = lo;
    else if (d8 > hi) d8 = hi;
    den = hi - lo;
    if (lvl_count == 0) begin
      q = 0;
    end else if (den == 0) begin
      q = d8 > 0 ? 32767 : (d8 < 0 ? -32768 : 0);
    end else begin
      num = d8 * longint'(lvl_count);
      q = num / den;
      if (num % den != 0 && ((num < 0) != (den < 0))) q = q - 1;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
    end
    r.density = d8[15:0];
    r.level   = q[15:0];
    r.in_mask = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    px_res_t exp_r;
    px_res_t got_r;
    if (!rst_ni) begin
      dens_min  = -16'sd512;
      dens_max  = 16'sd2048;
      lvl_count = 8'd10;
      dens_fill = 16'sd0;
      lvl_fill  = -16'sd1;
      expected_px.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDensityMin:  dens_min = cfg_data_i;
          RegDensityMax:  dens_max = cfg_data_i;
          RegLevelCount:  lvl_count = cfg_data_i[7:0];
          RegDensityFill: dens_fill = cfg_data_i;
          RegLevelFill:   lvl_fill = cfg_data_i;
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        expected_px.push_back(classify_pixel(pix.blue_band, pix.green_band, pix.red_band,
                                             pix.nir_band, pix.water_distance));
      end
      if (res.valid && res.ready) begin
        got_r = '{res.density, res.level, res.in_mask};
        if (expected_px.size() == 0) begin
          if (fail_cnt_o < 10)
            $display("unexpected result: density %0d level %0d mask %0b",
                     $signed(got_r.density), $signed(got_r.level), got_r.in_mask);
          fail_cnt_o++;
        end else begin
          exp_r = expected_px.pop_front();
          if (got_r !== exp_r) begin
            if (fail_cnt_o < 10)
              $display("mismatch: exp density %0d level %0d mask %0b, got %0d %0d %0b",
                       $signed(exp_r.density), $signed(exp_r.level), exp_r.in_mask,
                       $signed(got_r.density), $signed(got_r.level), got_r.in_mask);
            fail_cnt_o++;
          end
        end
      end
      pending_o = expected_px.size();
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import vdl_pkg::*;

  localparam int WatchLimit = 20000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [15:0]        cfg_data;
  int                 fail_cnt;
  int                 pending;
  int                 idle_cycles;
  int                 stall_left;
  bit                 sink_free;
  bit                 src_free;

  vdl_pix_if pix ();
  vdl_res_if res ();

  vegetation_density_level u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .pix_i     (pix),
    .res_o     (res)
  );

  vdl_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .pix       (pix),
    .res       (res),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sink stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left--;
    end else begin
      res.ready <= 1'b1;
      if (!sink_free && $urandom_range(0, 99) < 25) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_pixel(logic [15:0] b, g, r, n, d);
    int gap;
    gap = src_free ? 0 : gap_len();
    if (gap > 0) begin
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix.valid          = 1'b1;
    pix.blue_band      = b;
    pix.green_band     = g;
    pix.red_band       = r;
    pix.nir_band       = n;
    pix.water_distance = d;
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
    pix.valid = 1'b0;
  endtask

  task automatic send_random_pixel();
    int          kind;
    logic [15:0] b, g, r, n, d;
    kind = $urandom_range(0, 99);
    b = 16'($urandom_range(0, 4095));
    g = 16'($urandom_range(0, 4095));
    r = 16'($urandom_range(0, 4095));
    n = 16'($urandom_range(0, 6000));
    d = $urandom_range(0, 99) < 70 ? 16'($urandom_range(0, 2000)) : 16'($urandom);
    if (kind < 20) begin
      b = 16'($urandom_range(0, 300));
      g = 16'($urandom_range(0, 300));
      r = 16'($urandom_range(0, 300));
      n = 16'($urandom_range(0, 300));
    end else if (kind < 40) begin
      b = 16'($urandom);
      g = 16'($urandom);
      r = {1'b0, 15'($urandom)};
      n = {1'b0, 15'($urandom)};
    end else if (kind < 55) begin
      b = 16'($urandom);
      g = 16'($urandom);
      r = 16'($urandom);
      n = 16'($urandom);
    end else if (kind < 63) begin
      if ($urandom_range(0, 1)) r = {1'b1, 15'($urandom)};
      else n = {1'b1, 15'($urandom)};
    end else if (kind < 68) begin
      r = 16'd0;
      n = 16'd0;
    end
    send_pixel(b, g, r, n, d);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] lo, hi, logic [7:0] cnt, logic [15:0] df, lf);
    wait_drained();
    write_reg(RegDensityMin, lo);
    write_reg(RegDensityMax, hi);
    write_reg(RegLevelCount, {8'd0, cnt});
    write_reg(RegDensityFill, df);
    write_reg(RegLevelFill, lf);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = RegDensityMin;
    cfg_data           = 16'd0;
    pix.valid          = 1'b0;
    pix.blue_band      = 16'd0;
    pix.green_band     = 16'd0;
    pix.red_band       = 16'd0;
    pix.nir_band       = 16'd0;
    pix.water_distance = 16'd0;
    res.ready          = 1'b0;
    stall_left         = 0;
    idle_cycles        = 0;
    sink_free          = 1'b0;
    src_free           = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed pixels under reset settings
    send_pixel(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    send_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
    send_pixel(16'h0100, 16'h0100, 16'h8000, 16'h1000, 16'h0010);
    send_pixel(16'h0100, 16'h0100, 16'h1000, 16'hffff, 16'h0010);
    send_pixel(16'h8000, 16'h8000, 16'h0000, 16'h7fff, 16'h0000);
    send_pixel(16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
    send_pixel(16'h7fff, 16'h7fff, 16'h0001, 16'h0000, 16'hffff);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
    send_pixel(16'hc000, 16'hc000, 16'h0010, 16'h0040, 16'h0000);
    send_pixel(16'h0200, 16'h0300, 16'h0100, 16'h0800, 16'h0040);

    set_config(16'h8000, 16'h7fff, 8'd255, 16'h7fff, 16'h8000);
    send_pixel(16'h8000, 16'h8000, 16'h0000, 16'h7fff, 16'h0000);
    send_pixel(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    send_pixel(16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0000);
    send_pixel(16'hc000, 16'hc000, 16'h0000, 16'h0000, 16'h0000);

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_config(16'h8000, 16'h7fff, 8'd255, 16'h7fff, 16'h8000);
        1: set_config(16'h7fff, 16'h8000, 8'd1, 16'h8000, 16'h7fff);   // inverted range
        2: set_config(16'h0064, 16'h0064, 8'd7, 16'h1234, 16'h0005);   // zero-width range
        3: set_config(16'hfe00, 16'h0800, 8'd0, 16'hffff, 16'h0000);   // zero count
        4: set_config(16'h0000, 16'h0000, 8'd3, 16'h0000, 16'hffff);
        default: begin
          set_config(16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                     16'($urandom));
        end
      endcase
      src_free  = (ph == 4);
      sink_free = (ph == 5);
      for (int i = 0; i < 55; i++) begin
        if (ph == 6 && i == 25) wait_drained();
        send_random_pixel();
      end
    end

    src_free  = 1'b0;
    sink_free = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
